### design/lbsd_pkg.sv
// lbsd_pkg: shared types and constants for the lzss byte stream decoder
// no dependencies; imported by lbsd_window, lbsd_seq and the top level
`default_nettype none

package lbsd_pkg;

	// window geometry
	localparam int WIN_DEPTH = 4096;
	localparam int PTR_W     = $clog2(WIN_DEPTH);
	localparam int BYTE_W    = 8;
	localparam int NIB_W     = 4;
	localparam int POS_HI_W  = PTR_W - NIB_W;

	// run length: low nibble of the length byte plus a base of three
	localparam int LEN_BASE = 3;
	localparam int RUN_W    = 5;

	// token parsing phase
	typedef enum logic [1:0] {
		PH_IND    = 2'd0,
		PH_POS_HI = 2'd1,
		PH_POS_LO = 2'd2,
		PH_LEN    = 2'd3
	} tok_phase_t;

	// copy sequencer states
	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_READ = 2'd1,
		ST_EMIT = 2'd2
	} seq_state_t;

	// request to the history window
	typedef struct packed {
		logic              we;
		logic              re;
		logic [PTR_W-1:0]  waddr;
		logic [PTR_W-1:0]  raddr;
		logic [BYTE_W-1:0] wdata;
	} win_req_t;

	// one output item from the sequencer
	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
		logic              last;
	} emit_t;

endpackage

`default_nettype wire

### design/lbsd_window.sv
// lbsd_window: 4096 x 8 history window, one write and one registered read port
// depends on lbsd_pkg; entries never written read as zero via a wrap flag
`default_nettype none

module lbsd_window
	import lbsd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire win_req_t          req,
	output logic      [BYTE_W-1:0] rdata
);

	logic [BYTE_W-1:0] mem [WIN_DEPTH];
	logic [BYTE_W-1:0] raw_q;
	logic              hit_q;
	logic              wrap_q;
	logic              written;

	// writes go in address order from zero, so an entry holds data once the
	// pointer has passed it or the pointer has wrapped at least once
	assign written = wrap_q || (req.raddr < req.waddr);

	// memory array
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			raw_q <= mem[req.raddr];
			hit_q <= written;
		end
	end

	// sticky wrap flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_q <= 1'b0;
		end else if (req.we && (req.waddr == PTR_W'(WIN_DEPTH - 1))) begin
			wrap_q <= 1'b1;
		end
	end

	assign rdata = hit_q ? raw_q : '0;

	// assertions
	a_wrap_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		wrap_q |=> wrap_q)
		else $error("wrap flag dropped");

	a_wrap_sets: assert property (@(posedge clk) disable iff (!arst_n)
		(req.we && (req.waddr == PTR_W'(WIN_DEPTH - 1))) |=> wrap_q)
		else $error("wrap flag not set on last entry write");

	a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.we && req.re))
		else $error("window read and write in one cycle");

endmodule

`default_nettype wire

### design/lbsd_seq.sv
// lbsd_seq: token parser and copy sequencer around one shared 12-bit incrementer
// depends on lbsd_pkg; drives lbsd_window requests and emits output items
`default_nettype none

module lbsd_seq
	import lbsd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [BYTE_W-1:0] in_byte,
	input  wire logic              out_free,
	input  wire logic [BYTE_W-1:0] rdata,
	output win_req_t               req,
	output emit_t                  emit
);

	seq_state_t          state_q, state_d;
	tok_phase_t          phase_q;
	logic [POS_HI_W-1:0] pos_hi_q;
	logic [NIB_W-1:0]    pos_lo_q;
	logic [PTR_W-1:0]    wptr_q;
	logic [PTR_W-1:0]    src_q;
	logic [RUN_W-1:0]    rem_q;
	logic [PTR_W-1:0]    inc_op;
	logic [PTR_W-1:0]    inc_sum;
	logic                acc;

	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign acc      = in_valid && in_ready;

	// shared incrementer: source address while reading, write pointer otherwise
	assign inc_op  = (state_q == ST_READ) ? src_q : wptr_q;
	assign inc_sum = inc_op + PTR_W'(1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc && (phase_q == PH_LEN)) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = (rem_q == RUN_W'(1)) ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// window requests and output items
	always_comb begin
		req.we    = 1'b0;
		req.re    = 1'b0;
		req.waddr = wptr_q;
		req.raddr = src_q;
		req.wdata = in_byte;
		emit.valid = 1'b0;
		emit.data  = in_byte;
		emit.last  = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (acc && (phase_q == PH_IND) && (in_byte != '0)) begin
					req.we     = 1'b1;
					emit.valid = 1'b1;
				end
			end
			ST_READ: begin
				req.re = 1'b1;
			end
			ST_EMIT: begin
				req.wdata = rdata;
				emit.data = rdata;
				emit.last = (rem_q == RUN_W'(1));
				if (out_free) begin
					req.we     = 1'b1;
					emit.valid = 1'b1;
				end
			end
			default: begin
				req.re = 1'b0;
			end
		endcase
	end

	// control state and token fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			phase_q  <= PH_IND;
			pos_hi_q <= '0;
			pos_lo_q <= '0;
			wptr_q   <= '0;
			rem_q    <= '0;
		end else begin
			state_q <= state_d;
			if (req.we) begin
				wptr_q <= inc_sum;
			end
			if ((state_q == ST_EMIT) && out_free) begin
				rem_q <= rem_q - RUN_W'(1);
			end
			if (acc) begin
				case (phase_q)
					PH_IND: begin
						if (in_byte == '0) begin
							phase_q <= PH_POS_HI;
						end
					end
					PH_POS_HI: begin
						pos_hi_q <= in_byte[POS_HI_W-1:0];
						phase_q  <= PH_POS_LO;
					end
					PH_POS_LO: begin
						pos_lo_q <= in_byte[BYTE_W-1:BYTE_W-NIB_W];
						phase_q  <= PH_LEN;
					end
					PH_LEN: begin
						rem_q   <= RUN_W'(in_byte[NIB_W-1:0]) + RUN_W'(LEN_BASE);
						phase_q <= PH_IND;
					end
					default: begin
						phase_q <= PH_IND;
					end
				endcase
			end
		end
	end

	// copy source address
	always_ff @(posedge clk) begin
		if (acc && (phase_q == PH_LEN)) begin
			src_q <= {pos_hi_q, pos_lo_q};
		end else if (state_q == ST_READ) begin
			src_q <= inc_sum;
		end
	end

	// assertions
	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (rem_q != '0))
		else $error("copy running with empty run count");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_free && rem_q == RUN_W'(1)) |=> (state_q == ST_IDLE))
		else $error("copy did not end after last byte");

	a_wptr_step: assert property (@(posedge clk) disable iff (!arst_n)
		emit.valid |=> (wptr_q == $past(wptr_q) + PTR_W'(1)))
		else $error("write pointer did not advance with an emitted item");

	a_literal_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && phase_q == PH_IND && in_byte != '0) |-> (emit.valid && emit.last))
		else $error("literal not emitted");

endmodule

`default_nettype wire

### design/lzss_byte_stream_decoder_core.sv
// lzss_byte_stream_decoder_core: top level of the lzss byte stream decoder
// depends on lbsd_pkg, lbsd_window and lbsd_seq; holds the output register
//
// Takes the compressed stream one byte per item on the s_ side and gives
// decompressed bytes on the m_ side, m_tlast marking the final byte caused
// by one input item. The last byte of a match token starts a run of L
// bytes (3 to 18): each byte needs a registered read of the history
// window and then a write-back and emit, and s_tready stays low until
// the run is done. A full output register that is not being drained
// also holds off input. The window reads as zero until written; a wrap
// flag in the window, checked against the write address, tracks that, so
// no clearing pass follows reset.
`default_nettype none

module lzss_byte_stream_decoder_core
	import lbsd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] in_byte
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic      [7:0] m_tdata,   // [7:0] out_byte
	output logic            m_tlast    // run_last
);

	win_req_t          req;
	emit_t             emit;
	logic [BYTE_W-1:0] rdata;
	logic              out_free;
	logic              ovld_q;
	logic [BYTE_W-1:0] obyte_q;
	logic              olast_q;

	assign out_free = !ovld_q || m_tready;

	lbsd_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rdata  (rdata)
	);

	lbsd_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.out_free (out_free),
		.rdata    (rdata),
		.req      (req),
		.emit     (emit)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (emit.valid) begin
			ovld_q <= 1'b1;
		end else if (m_tready) begin
			ovld_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (emit.valid) begin
			obyte_q <= emit.data;
			olast_q <= emit.last;
		end
	end

	assign m_tvalid = ovld_q;
	assign m_tdata  = obyte_q;
	assign m_tlast  = olast_q;

	// assertions
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit.valid |-> out_free)
		else $error("item written over a pending output");

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
		else $error("output item changed while stalled");

	a_ready_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> out_free)
		else $error("input taken with no output room");

endmodule

`default_nettype wire

### tb/tb_lzss_byte_stream_decoder_core.sv
// tb_lzss_byte_stream_decoder_core: self-checking bench for the lzss byte stream decoder
// depends on lbsd_pkg and lzss_byte_stream_decoder_core; predicts output bytes from a
// behavioral copy of the history window or fixed directed values, and checks them in order
`default_nettype none

module tb_lzss_byte_stream_decoder_core;
	import lbsd_pkg::*;

	localparam logic [7:0] IND_BYTE       = 8'h00;
	localparam int         WATCHDOG_LIMIT = 3000;
	localparam int         HOLD_CYCLES    = 400;
	localparam int         DRAIN_CYCLES   = 64;
	localparam int         RAND_ITEMS     = 80;
	localparam int         LONG_TOKENS    = 20;
	localparam int         DIR_N          = 23;

	// one decompressed output item
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} out_item_t;

	// directed row: input byte, and where fixed, a run of cnt copies of want
	typedef struct packed {
		logic [7:0] stim;
		logic       fixed;
		logic [7:0] want;
		logic [4:0] cnt;
	} dir_row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic       m_tlast;

	// decoder shadow state
	tok_phase_t        dec_phase;
	logic [7:0]        dec_pos_hi;
	logic [3:0]        dec_pos_lo;
	logic [PTR_W-1:0]  dec_wr_ptr;
	logic [7:0]        dec_hist [WIN_DEPTH];

	out_item_t run_bytes[$];
	out_item_t expected_bytes[$];
	out_item_t want_item;
	dir_row_t  dir_rows [DIR_N];

	int err_cnt     = 0;
	int checked_cnt = 0;
	int items_sent  = 0;
	int literal_cnt = 0;
	int token_cnt   = 0;
	int wrap_cnt    = 0;
	int idle_cycles = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_reqs   = 0;
	int hold_seen   = 0;

	lzss_byte_stream_decoder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// clock, period 12
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// write one byte into the shadow window and emit it
	function automatic void store_byte(input logic [7:0] b, input logic last);
		dec_hist[dec_wr_ptr] = b;
		dec_wr_ptr = dec_wr_ptr + PTR_W'(1);
		if (dec_wr_ptr == '0)
			wrap_cnt++;
		run_bytes.push_back('{b, last});
	endfunction

	// advance the shadow decoder by one input byte, results left in run_bytes
	function automatic void decode_byte(input logic [7:0] b);
		logic [PTR_W-1:0] src;
		int               run_len;
		run_bytes.delete();
		case (dec_phase)
			PH_IND: begin
				if (b == IND_BYTE)
					dec_phase = PH_POS_HI;
				else
					store_byte(b, 1'b1);
			end
			PH_POS_HI: begin
				dec_pos_hi = b;
				dec_phase  = PH_POS_LO;
			end
			PH_POS_LO: begin
				dec_pos_lo = b[7:4];
				dec_phase  = PH_LEN;
			end
			default: begin
				dec_phase = PH_IND;
				run_len   = int'(b[3:0]) + LEN_BASE;
				src       = {dec_pos_hi, dec_pos_lo};
				for (int i = 0; i < run_len; i++) begin
					store_byte(dec_hist[src], (i == run_len - 1) ? 1'b1 : 1'b0);
					src = src + PTR_W'(1);
				end
			end
		endcase
	endfunction

	// offer one item, wait for acceptance, then queue its expected bytes
	task automatic send_byte(input logic [7:0] b, input logic fixed = 1'b0,
			input logic [7:0] want = 8'h00, input logic [4:0] cnt = 5'd0);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		decode_byte(b);
		if (fixed) begin
			for (int k = 0; k < cnt; k++)
				expected_bytes.push_back('{want, (k == cnt - 1) ? 1'b1 : 1'b0});
		end else begin
			foreach (run_bytes[k])
				expected_bytes.push_back(run_bytes[k]);
		end
	endtask

	// four-byte match token with random filler in the unused nibbles
	task automatic send_token(input logic [PTR_W-1:0] pos, input logic [3:0] len_nib);
		logic [3:0] pad_lo;
		logic [3:0] pad_hi;
		pad_lo = 4'($urandom_range(15));
		pad_hi = 4'($urandom_range(15));
		token_cnt++;
		send_byte(IND_BYTE);
		send_byte(pos[PTR_W-1:NIB_W]);
		send_byte({pos[NIB_W-1:0], pad_lo});
		send_byte({pad_hi, len_nib});
	endtask

	// mostly literals and well-formed tokens, some raw noise bytes
	task automatic random_items(input int n);
		int               cnt;
		int               pick;
		logic [PTR_W-1:0] pos;
		cnt = 0;
		while (cnt < n) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				literal_cnt++;
				send_byte(8'($urandom_range(255, 1)));
				cnt++;
			end else if (pick < 93) begin
				// recent history gives overlapping copies
				if ($urandom_range(1) == 1)
					pos = dec_wr_ptr - PTR_W'($urandom_range(48, 1));
				else
					pos = PTR_W'($urandom_range(WIN_DEPTH - 1));
				send_token(pos, 4'($urandom_range(15)));
				cnt += 4;
			end else begin
				send_byte(8'($urandom_range(255)));
				cnt++;
			end
		end
	endtask

	// drop valid and let every expected byte come out
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
	endtask

	// receiver: random backpressure, plus one long hold on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seen != hold_reqs) begin
				hold_seen = hold_reqs;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// output checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			checked_cnt++;
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected item data=%02h last=%0b", $time, m_tdata, m_tlast);
				err_cnt++;
			end else begin
				want_item = expected_bytes.pop_front();
				if (m_tdata !== want_item.data) begin
					$display("%0t: out_byte mismatch expected=%02h actual=%02h",
						$time, want_item.data, m_tdata);
					err_cnt++;
				end
				if (m_tlast !== want_item.last) begin
					$display("%0t: run_last mismatch expected=%0b actual=%0b",
						$time, want_item.last, m_tlast);
					err_cnt++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d bytes still expected",
				$time, expected_bytes.size());
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// main sequence
	initial begin
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = 8'h00;
		dec_phase  = PH_IND;
		dec_pos_hi = '0;
		dec_pos_lo = '0;
		dec_wr_ptr = '0;
		foreach (dec_hist[k])
			dec_hist[k] = 8'h00;

		// directed rows; window is all zero after reset
		dir_rows = '{
			'{8'h00, 1'b1, 8'h00, 5'd0},   // indicator
			'{8'h00, 1'b1, 8'h00, 5'd0},   // position high zero
			'{8'h0F, 1'b1, 8'h00, 5'd0},   // position low zero, unused nibble set
			'{8'hF0, 1'b1, 8'h00, 5'd3},   // shortest run, unused nibble set
			'{8'hFF, 1'b1, 8'hFF, 5'd1},   // largest literal
			'{8'h01, 1'b1, 8'h01, 5'd1},   // smallest literal
			'{8'h80, 1'b0, 8'h00, 5'd0},
			'{8'h00, 1'b0, 8'h00, 5'd0},   // longest run from the top slot, source wraps
			'{8'hFF, 1'b0, 8'h00, 5'd0},
			'{8'hF0, 1'b0, 8'h00, 5'd0},
			'{8'h0F, 1'b0, 8'h00, 5'd0},
			'{8'h41, 1'b1, 8'h41, 5'd1},   // literal at slot 24
			'{8'h00, 1'b1, 8'h00, 5'd0},   // copy from slot 24 into slot 25 on
			'{8'h01, 1'b1, 8'h00, 5'd0},
			'{8'h80, 1'b1, 8'h00, 5'd0},
			'{8'h05, 1'b1, 8'h41, 5'd8},   // overlapping copy repeats the literal
			'{8'h7F, 1'b0, 8'h00, 5'd0},
			'{8'h00, 1'b1, 8'h00, 5'd0},   // copy from never written slots
			'{8'hAA, 1'b1, 8'h00, 5'd0},
			'{8'h5F, 1'b1, 8'h00, 5'd0},
			'{8'hFA, 1'b1, 8'h00, 5'd13},
			'{8'h55, 1'b0, 8'h00, 5'd0},
			'{8'hAA, 1'b0, 8'h00, 5'd0}
		};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part, no idling
		foreach (dir_rows[k])
			send_byte(dir_rows[k].stim, dir_rows[k].fixed, dir_rows[k].want, dir_rows[k].cnt);
		wait_drained();

		// sender sparse, receiver heavily stalled
		tx_idle_pct = 29;
		rx_idle_pct = 57;
		random_items(RAND_ITEMS);
		wait_drained();

		// receiver sparse, sender heavily idle
		tx_idle_pct = 57;
		rx_idle_pct = 29;
		random_items(RAND_ITEMS);
		wait_drained();

		// no idling, with one long receiver hold while input keeps coming
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_reqs++;
		random_items(RAND_ITEMS);
		wait_drained();

		// burst of longest runs from random positions
		for (int k = 0; k < LONG_TOKENS; k++)
			send_token(PTR_W'($urandom_range(WIN_DEPTH - 1)), 4'hF);
		wait_drained();

		// truncated final token gives nothing
		send_byte(IND_BYTE);
		send_byte(8'h3C);
		send_byte(8'hC3);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d items: %0d literals, %0d match tokens, truncated tail",
			items_sent, literal_cnt, token_cnt);
		$display("checked %0d output bytes, write pointer wrapped %0d times",
			checked_cnt, wrap_cnt);
		if (err_cnt == 0 && expected_bytes.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
design/lbsd_pkg.sv
design/lbsd_window.sv
design/lbsd_seq.sv
design/lzss_byte_stream_decoder_core.sv
tb/tb_lzss_byte_stream_decoder_core.sv
